[sv/numeric_char_reference_decoder_top_defines.svh]
// numeric_char_reference_decoder_top_defines.svh: assertion macros for the decoder
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef NUMERIC_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH
`define NUMERIC_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NCRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncrd assertion failed");

// next-cycle implication, checked outside reset
`define NCRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncrd assertion failed");

`endif

[sv/ncrd_pkg.sv]
// ncrd_pkg: types, code unit constants and helpers for the reference decoder
// no dependencies
package ncrd_pkg;

    // scan state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_HASH,
        MODE_DIGITS
    } ncrd_mode_t;

    // code units with a meaning to the scanner
    localparam logic [15:0] CU_AMP  = 16'h0026;
    localparam logic [15:0] CU_HASH = 16'h0023;
    localparam logic [15:0] CU_X    = 16'h0078;
    localparam logic [15:0] CU_SEMI = 16'h003B;

    // accumulator limit
    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

    // result queue size
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W = $clog2(Q_DEPTH);

    // input word
    typedef struct packed {
        logic [15:0] code_unit;
        logic        text_end;
    } ncrd_in_t;

    // output word
    typedef struct packed {
        logic [15:0] out_unit;
        logic        run_last;
        logic        out_text_end;
    } ncrd_out_t;

    // up to two units produced by one input word
    typedef struct packed {
        logic [1:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
    } ncrd_pend_t;

    // words handed from the scanner to the result queue
    typedef struct packed {
        logic [1:0] n;
        ncrd_out_t  e0;
        ncrd_out_t  e1;
    } ncrd_push_t;

    // append one unit, dropping anything past two
    function automatic ncrd_pend_t pend_push(ncrd_pend_t p, logic [15:0] u);
        ncrd_pend_t r;
        r = p;
        if (p.n == 2'd0)
        begin
            r.u0 = u;
            r.n  = 2'd1;
        end
        else if (p.n == 2'd1)
        begin
            r.u1 = u;
            r.n  = 2'd2;
        end
        return r;
    endfunction

endpackage

[sv/ncrd_scan.sv]
// ncrd_scan: reference scanner state and per-word decode
// depends on ncrd_pkg and numeric_char_reference_decoder_top_defines.svh
`include "numeric_char_reference_decoder_top_defines.svh"

module ncrd_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ncrd_pkg::ncrd_in_t item,
    output ncrd_pkg::ncrd_push_t push
);
    import ncrd_pkg::*;

    ncrd_mode_t  mode_reg, mode_next;
    logic        hex_reg, hex_next;
    logic [30:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;

    logic [15:0] c;
    logic        is_dec, is_uc, is_lc, is_digit;
    logic [3:0]  dval;
    logic [34:0] prod, vsum;
    logic        over;
    logic [15:0] ref_val;
    logic        do_fresh, do_digit;
    ncrd_pend_t  p;

    assign c = item.code_unit;

    // digit classification and value
    always_comb
    begin
        is_dec   = (c >= 16'h0030) && (c <= 16'h0039);
        is_uc    = hex_reg && (c >= 16'h0041) && (c <= 16'h0046);
        is_lc    = hex_reg && (c >= 16'h0061) && (c <= 16'h0066);
        is_digit = is_dec || is_uc || is_lc;
        if (is_uc)
            dval = 4'(c - 16'h0037);
        else if (is_lc)
            dval = 4'(c - 16'h0057);
        else
            dval = c[3:0];
    end

    // accumulate by 10 or 16 with overflow check
    always_comb
    begin
        if (hex_reg)
            prod = {acc_reg, 4'b0000};
        else
            prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        vsum = prod + {31'd0, dval};
        over = ovf_reg || (vsum[34:31] != 4'd0);
    end

    assign ref_val = ovf_reg ? 16'd0 : acc_reg[15:0];

    // next state and produced units
    always_comb
    begin
        p         = '0;
        mode_next = mode_reg;
        hex_next  = hex_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        do_fresh  = 1'b0;
        do_digit  = 1'b0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                do_fresh = 1'b1;
            end
            MODE_AMP:
            begin
                if (c == CU_HASH)
                begin
                    hex_next  = 1'b0;
                    acc_next  = '0;
                    ovf_next  = 1'b0;
                    mode_next = MODE_HASH;
                end
                else
                begin
                    p        = pend_push(p, CU_AMP);
                    do_fresh = 1'b1;
                end
            end
            MODE_HASH:
            begin
                if (c == CU_X)
                begin
                    hex_next  = 1'b1;
                    mode_next = MODE_DIGITS;
                end
                else
                    do_digit = 1'b1;
            end
            MODE_DIGITS:
            begin
                do_digit = 1'b1;
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // digit or end of reference
        if (do_digit)
        begin
            if (is_digit)
            begin
                acc_next  = over ? ACC_MAX : vsum[30:0];
                ovf_next  = over;
                mode_next = MODE_DIGITS;
            end
            else
            begin
                p         = pend_push(p, ref_val);
                hex_next  = 1'b0;
                acc_next  = '0;
                ovf_next  = 1'b0;
                mode_next = MODE_IDLE;
                do_fresh  = (c != CU_SEMI);
            end
        end

        // unit scanned fresh
        if (do_fresh)
        begin
            if (c == CU_AMP)
                mode_next = MODE_AMP;
            else
            begin
                mode_next = MODE_IDLE;
                p         = pend_push(p, c);
            end
        end

        // flush at end of text
        if (item.text_end)
        begin
            if (mode_next == MODE_AMP)
                p = pend_push(p, CU_AMP);
            else if (mode_next == MODE_HASH || mode_next == MODE_DIGITS)
                p = pend_push(p, ovf_next ? 16'd0 : acc_next[15:0]);
            mode_next = MODE_IDLE;
            hex_next  = 1'b0;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    // words for the result queue
    always_comb
    begin
        push.n                  = accept ? p.n : 2'd0;
        push.e0.out_unit        = p.u0;
        push.e0.run_last        = (p.n == 2'd1);
        push.e0.out_text_end    = (p.n == 2'd1) && item.text_end;
        push.e1.out_unit        = p.u1;
        push.e1.run_last        = 1'b1;
        push.e1.out_text_end    = item.text_end;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hex_reg  <= 1'b0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

    // overflow leaves the accumulator saturated
    `NCRD_ASSERT_NOW(a_ovf_sat, ovf_reg, acc_reg == ACC_MAX)
    // outside a reference the accumulator is clear
    `NCRD_ASSERT_NOW(a_idle_clear, (mode_reg == MODE_IDLE) || (mode_reg == MODE_AMP), (acc_reg == 31'd0) && !ovf_reg && !hex_reg)
    // end of text always yields a result and returns to idle
    `NCRD_ASSERT_NEXT(a_end_idle, accept && item.text_end, mode_reg == MODE_IDLE)

endmodule

[sv/ncrd_outq.sv]
// ncrd_outq: shifting result queue, up to two words in and one out per cycle
// depends on ncrd_pkg and numeric_char_reference_decoder_top_defines.svh
`include "numeric_char_reference_decoder_top_defines.svh"

module ncrd_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ncrd_pkg::ncrd_push_t push,
    output logic                 room,
    output logic                 valid,
    input  logic                 ready,
    output ncrd_pkg::ncrd_out_t  data
);
    import ncrd_pkg::*;

    ncrd_out_t             q_reg [Q_DEPTH];
    ncrd_out_t             q_next [Q_DEPTH];
    ncrd_out_t             shifted [Q_DEPTH];
    logic [Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [Q_CNT_W-1:0]    base;
    logic                  pop;

    assign valid = (cnt_reg != '0);
    assign data  = q_reg[0];
    assign pop   = valid && ready;
    assign room  = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));

    // shift on pop, then append new words behind the survivors
    always_comb
    begin
        base = cnt_reg - Q_CNT_W'(pop);
        for (int i = 0; i < Q_DEPTH - 1; i++)
            shifted[i] = pop ? q_reg[i + 1] : q_reg[i];
        shifted[Q_DEPTH - 1] = q_reg[Q_DEPTH - 1];
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = shifted[i];
            if ((push.n != 2'd0) && (base == Q_CNT_W'(i)))
                q_next[i] = push.e0;
            if ((push.n == 2'd2) && (base + Q_CNT_W'(1) == Q_CNT_W'(i)))
                q_next[i] = push.e1;
        end
        cnt_next = base + Q_CNT_W'(push.n);
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // never more words than entries
    `NCRD_ASSERT_NOW(a_cnt_max, 1'b1, cnt_reg <= Q_CNT_W'(Q_DEPTH))
    // words arrive only when two entries are free
    `NCRD_ASSERT_NOW(a_push_room, push.n != 2'd0, room)
    // fill count follows pushes and pops
    `NCRD_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_reg == $past(cnt_reg) + Q_CNT_W'($past(push.n)) - Q_CNT_W'($past(pop)))

endmodule

[sv/numeric_char_reference_decoder_top.sv]
// numeric_char_reference_decoder_top: decodes &#NNN; and &#xHH; references in a 16-bit stream
// depends on ncrd_pkg, ncrd_scan, ncrd_outq
//
//  channel  | valid         | ready         | word
//  ---------+---------------+---------------+----------------------------------------
//  input    | item_valid    | item_ready    | item   (code_unit, text_end)
//  output   | result_valid  | result_ready  | result (out_unit, run_last, out_text_end)
//
// one input word is taken per cycle; its 0 to 2 result words enter a 4-entry queue
// in the same cycle and leave it one per cycle, so a word yielding two results
// leaves as two output words. item_ready is high while the queue has two free entries.
// reset (rst_n low, async) returns the scanner to idle and empties the queue.
// an output stall fills the queue and then holds off input; nothing is dropped.

module numeric_char_reference_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  ncrd_pkg::ncrd_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output ncrd_pkg::ncrd_out_t result
);
    import ncrd_pkg::*;

    ncrd_push_t push;
    logic       accept;

    assign accept = item_valid && item_ready;

    // scanner: state update and unit production
    ncrd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    // result queue
    ncrd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (item_ready),
        .valid (result_valid),
        .ready (result_ready),
        .data  (result)
    );

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for numeric_char_reference_decoder_top
// depends on ncrd_pkg and the decoder rtl; random streams of code units with checked output
`timescale 1ns / 100ps

module tb_top;
    import ncrd_pkg::*;

    // plain characters used to build references
    localparam logic [15:0] CH_0  = 16'h0030;
    localparam logic [15:0] CH_UA = 16'h0041;
    localparam logic [15:0] CH_UF = 16'h0046;
    localparam logic [15:0] CH_UX = 16'h0058;
    localparam logic [15:0] CH_LA = 16'h0061;
    localparam logic [15:0] CH_LQ = 16'h0071;

    localparam int RANDOM_WORDS = 1900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOW_MAX     = 10;

    // one stimulus word, optionally with its results typed in
    typedef struct packed {
        ncrd_in_t   w;
        logic       typed;
        logic [1:0] n;
        ncrd_out_t  r0;
        ncrd_out_t  r1;
    } stim_row_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    ncrd_in_t   item;
    logic       result_valid;
    logic       result_ready = 1'b0;
    ncrd_out_t  result;

    stim_row_t  cur_row      = '0;
    stim_row_t  text_words[$];
    ncrd_out_t  due_words[$];

    // shared pacing controls
    logic       calm         = 1'b0;
    logic       hold_req     = 1'b0;

    int         errors       = 0;
    int         quiet_cycles = 0;

    // decoder state as predicted
    ncrd_mode_t  scan_q = MODE_IDLE;
    logic        hex_q  = 1'b0;
    logic [30:0] acc_q  = '0;
    logic        ovf_q  = 1'b0;
    logic [15:0] pend_u[0:1];
    int          pend_n;

    ncrd_out_t   got;
    ncrd_out_t   want;
    int          k;

    assign item = cur_row.w;

    always #2 clk = ~clk;

    numeric_char_reference_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    task automatic emit_unit(input logic [15:0] u);
        if (pend_n < 2)
        begin
            pend_u[pend_n] = u;
            pend_n++;
        end
    endtask

    task automatic forget_ref();
        hex_q = 1'b0;
        acc_q = '0;
        ovf_q = 1'b0;
    endtask

    function automatic logic [15:0] ref_value();
        return ovf_q ? 16'h0000 : acc_q[15:0];
    endfunction

    // an ampersand opens a reference, anything else passes through
    task automatic open_or_pass(input logic [15:0] c);
        if (c == CU_AMP)
            scan_q = MODE_AMP;
        else
        begin
            scan_q = MODE_IDLE;
            emit_unit(c);
        end
    endtask

    // digit extends the value; any other unit closes the reference
    task automatic take_digit(input logic [15:0] c);
        int          d;
        logic [35:0] v;
        d = -1;
        if (c >= CH_0 && c <= CH_0 + 16'd9)
            d = int'(c - CH_0);
        else if (hex_q && c >= CH_UA && c <= CH_UF)
            d = int'(c - CH_UA) + 10;
        else if (hex_q && c >= CH_LA && c <= CH_LA + 16'd5)
            d = int'(c - CH_LA) + 10;
        if (d >= 0)
        begin
            v = 36'(acc_q) * (hex_q ? 36'd16 : 36'd10) + 36'(d);
            if (ovf_q || v > 36'(ACC_MAX))
            begin
                ovf_q = 1'b1;
                acc_q = ACC_MAX;
            end
            else
                acc_q = v[30:0];
            scan_q = MODE_DIGITS;
        end
        else
        begin
            emit_unit(ref_value());
            forget_ref();
            scan_q = MODE_IDLE;
            if (c != CU_SEMI)
                open_or_pass(c);
        end
    endtask

    // next state and the 0 to 2 units caused by one input word
    task automatic decode_word(input ncrd_in_t w);
        pend_n = 0;
        case (scan_q)
            MODE_IDLE:
                open_or_pass(w.code_unit);
            MODE_AMP:
                if (w.code_unit == CU_HASH)
                begin
                    forget_ref();
                    scan_q = MODE_HASH;
                end
                else
                begin
                    emit_unit(CU_AMP);
                    open_or_pass(w.code_unit);
                end
            MODE_HASH:
                if (w.code_unit == CU_X)
                begin
                    hex_q  = 1'b1;
                    scan_q = MODE_DIGITS;
                end
                else
                begin
                    hex_q = 1'b0;
                    take_digit(w.code_unit);
                end
            default:
                take_digit(w.code_unit);
        endcase
        // end of text flushes whatever is pending
        if (w.text_end)
        begin
            if (scan_q == MODE_AMP)
                emit_unit(CU_AMP);
            else if (scan_q != MODE_IDLE)
                emit_unit(ref_value());
            scan_q = MODE_IDLE;
            forget_ref();
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic ncrd_out_t out_word(logic [15:0] u, logic rl, logic te);
        ncrd_out_t o;
        o.out_unit     = u;
        o.run_last     = rl;
        o.out_text_end = te;
        return o;
    endfunction

    task automatic add_row(input logic [15:0] u, input logic e, input logic typed,
                           input logic [1:0] n, input ncrd_out_t r0 = '0,
                           input ncrd_out_t r1 = '0);
        stim_row_t r;
        r.w.code_unit = u;
        r.w.text_end  = e;
        r.typed       = typed;
        r.n           = n;
        r.r0          = r0;
        r.r1          = r1;
        text_words.push_back(r);
    endtask

    // offer one word at the falling edge and hold it until taken
    task automatic send_word(input stim_row_t r);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 34)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        cur_row    = r;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    initial
    begin
        string     s;
        stim_row_t r;
        int        sent;
        int        kind;
        int        t;
        int        nd;
        int        hx;
        int        i;
        logic [15:0] u;

        // directed table, results typed in where they are obvious
        // extremes of the code unit, the second one closing a text
        add_row(16'hFFFF, 1'b0, 1'b1, 2'd1, out_word(16'hFFFF, 1'b1, 1'b0));
        add_row(16'h0000, 1'b1, 1'b1, 2'd1, out_word(16'h0000, 1'b1, 1'b1));
        // stray ampersand, then a mixed-case hex reference closed by a semicolon
        add_row(CU_AMP, 1'b0, 1'b1, 2'd0);
        add_row(CU_AMP, 1'b0, 1'b1, 2'd1, out_word(CU_AMP, 1'b1, 1'b0));
        add_row(CU_HASH, 1'b0, 1'b1, 2'd0);
        add_row(CU_X, 1'b0, 1'b1, 2'd0);
        add_row(CH_LA, 1'b0, 1'b1, 2'd0);
        add_row(CH_UA + 16'd1, 1'b0, 1'b1, 2'd0);
        add_row(CU_SEMI, 1'b0, 1'b0, 2'd0);
        // upper-case X gives an empty reference, then X is passed on
        add_row(CU_AMP, 1'b0, 1'b1, 2'd0);
        add_row(CU_HASH, 1'b0, 1'b1, 2'd0);
        add_row(CH_UX, 1'b0, 1'b1, 2'd2, out_word(16'h0000, 1'b0, 1'b0),
                out_word(CH_UX, 1'b1, 1'b0));
        // eight hex digits run past the limit; text ends on a plain unit
        add_row(CU_AMP, 1'b0, 1'b1, 2'd0);
        add_row(CU_HASH, 1'b0, 1'b1, 2'd0);
        add_row(CU_X, 1'b0, 1'b1, 2'd0);
        repeat (8)
            add_row(CH_UF, 1'b0, 1'b1, 2'd0);
        add_row(CH_LQ, 1'b1, 1'b1, 2'd2, out_word(16'h0000, 1'b0, 1'b0),
                out_word(CH_LQ, 1'b1, 1'b1));
        // empty hex reference still open at end of text
        add_row(CU_AMP, 1'b0, 1'b1, 2'd0);
        add_row(CU_HASH, 1'b0, 1'b1, 2'd0);
        add_row(CU_X, 1'b1, 1'b1, 2'd1, out_word(16'h0000, 1'b1, 1'b1));
        // lone ampersand at end of text
        add_row(CU_AMP, 1'b1, 1'b1, 2'd1, out_word(CU_AMP, 1'b1, 1'b1));

        // reset once
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_words.size() != 0)
            send_word(text_words.pop_front());

        // random text, mostly references with random content
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                add_row(CU_AMP, $urandom_range(39) == 0, 1'b0, 2'd0);
                add_row(CU_HASH, $urandom_range(39) == 0, 1'b0, 2'd0);
                // 0 decimal, 1 hex, 2 upper-case X
                t  = $urandom_range(9);
                hx = (t < 6) ? 1 : (t == 6) ? 2 : 0;
                if (hx == 1)
                    add_row(CU_X, $urandom_range(39) == 0, 1'b0, 2'd0);
                else if (hx == 2)
                    add_row(CH_UX, $urandom_range(39) == 0, 1'b0, 2'd0);
                if ($urandom_range(19) == 0)
                begin
                    // values right at the overflow limit
                    t = $urandom_range(1);
                    if (hx == 1)
                    begin
                        if (t != 0)
                            s = "80000000";
                        else if ($urandom_range(1) != 0)
                            s = "7FFFFFFF";
                        else
                            s = "7fffffff";
                    end
                    else if (t != 0)
                        s = "2147483648";
                    else
                        s = "2147483647";
                    for (i = 0; i < s.len(); i++)
                        add_row(16'(s[i]), 1'b0, 1'b0, 2'd0);
                end
                else
                begin
                    t  = $urandom_range(9);
                    nd = (t == 0) ? 0 :
                         (t == 1) ? $urandom_range(8, 11) : $urandom_range(1, 5);
                    for (i = 0; i < nd; i++)
                    begin
                        if (hx == 1)
                        begin
                            t = $urandom_range(21);
                            u = (t < 10) ? CH_0 + 16'(t) :
                                (t < 16) ? CH_LA + 16'(t - 10) : CH_UA + 16'(t - 16);
                        end
                        else
                            u = CH_0 + 16'($urandom_range(9));
                        add_row(u, $urandom_range(39) == 0, 1'b0, 2'd0);
                    end
                end
                // what closes the reference
                t = $urandom_range(9);
                if (t < 5)
                    add_row(CU_SEMI, $urandom_range(39) == 0, 1'b0, 2'd0);
                else if (t == 5)
                    add_row(CU_AMP, $urandom_range(39) == 0, 1'b0, 2'd0);
                else if (t == 6)
                    add_row(16'($urandom_range(65535)), $urandom_range(39) == 0, 1'b0, 2'd0);
                else if (t == 7)
                    add_row(16'($urandom_range(16'h7E, 16'h20)), 1'b0, 1'b0, 2'd0);
                else if (t == 8)
                begin
                    r = text_words.pop_back();
                    r.w.text_end = 1'b1;
                    text_words.push_back(r);
                end
            end
            else if (kind < 75)
            begin
                // plain text, full range or printable
                nd = $urandom_range(1, 4);
                for (i = 0; i < nd; i++)
                begin
                    if ($urandom_range(1) != 0)
                        u = 16'($urandom_range(65535));
                    else
                        u = 16'($urandom_range(16'h7E, 16'h20));
                    add_row(u, $urandom_range(39) == 0, 1'b0, 2'd0);
                end
            end
            else
            begin
                // broken references
                add_row(CU_AMP, 1'b0, 1'b0, 2'd0);
                case ($urandom_range(4))
                    0: add_row(CU_AMP, 1'b0, 1'b0, 2'd0);
                    1: add_row(CU_SEMI, 1'b0, 1'b0, 2'd0);
                    2: add_row(CU_X, 1'b0, 1'b0, 2'd0);
                    3: add_row(16'($urandom_range(65535)), $urandom_range(9) == 0, 1'b0, 2'd0);
                    default:
                    begin
                        add_row(CU_HASH, 1'b0, 1'b0, 2'd0);
                        add_row(16'($urandom_range(16'h7E, 16'h20)), 1'b0, 1'b0, 2'd0);
                    end
                endcase
            end

            while (text_words.size() != 0)
            begin
                send_word(text_words.pop_front());
                sent++;
                calm = (sent >= 700 && sent < 1000);
                if (sent == 300)
                    hold_req = 1'b1;
            end
        end

        // close the text so nothing stays pending
        r = '0;
        r.w.code_unit = 16'($urandom_range(16'h7E, 16'h20));
        r.w.text_end  = 1'b1;
        send_word(r);
        @(negedge clk);
        item_valid = 1'b0;

        // drain
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, one long hold-off, a calm stretch
    // ---------------------------------------------------------------
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            result_ready = calm || ($urandom_range(99) >= 34);
        end
    end

    // ---------------------------------------------------------------
    // monitor: predict on input words, check output words, watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // expected words for an accepted input word
            if (item_valid && item_ready)
            begin
                decode_word(item);
                if (cur_row.typed)
                begin
                    if (cur_row.n >= 2'd1)
                        due_words.push_back(cur_row.r0);
                    if (cur_row.n == 2'd2)
                        due_words.push_back(cur_row.r1);
                end
                else
                begin
                    for (k = 0; k < pend_n; k++)
                        due_words.push_back(out_word(pend_u[k], k == pend_n - 1,
                                                     (k == pend_n - 1) && item.text_end));
                end
            end

            // compare with the oldest expectation
            if (result_valid && result_ready)
            begin
                got = result;
                if (due_words.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("unexpected word: unit %h last %b end %b",
                                 got.out_unit, got.run_last, got.out_text_end);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.out_unit !== want.out_unit || got.run_last !== want.run_last
                        || got.out_text_end !== want.out_text_end)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display({"mismatch: expected unit %h last %b end %b, ",
                                      "got unit %h last %b end %b"},
                                     want.out_unit, want.run_last, want.out_text_end,
                                     got.out_unit, got.run_last, got.out_text_end);
                    end
                end
            end

            // watchdog on cycles with no word moving
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[sim.f]
+incdir+sv
sv/ncrd_pkg.sv
sv/ncrd_scan.sv
sv/ncrd_outq.sv
sv/numeric_char_reference_decoder_top.sv
tb/sv/tb_top.sv
